// ===== rtl/bdq_pkg.sv =====
// ----------------------------------------------------------------------------
// Deque engine package
// Action and status codes and fixed field widths shared by the deque engine.
// ----------------------------------------------------------------------------
package bdq_pkg;

    localparam int ACTION_W = 4;
    localparam int STATUS_W = 3;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 16;
    localparam int CFG_W    = 9;

    localparam logic [ACTION_W-1:0] ACT_PUSH_BACK  = 4'd0;
    localparam logic [ACTION_W-1:0] ACT_PUSH_FRONT = 4'd1;
    localparam logic [ACTION_W-1:0] ACT_POP_BACK   = 4'd2;
    localparam logic [ACTION_W-1:0] ACT_POP_FRONT  = 4'd3;
    localparam logic [ACTION_W-1:0] ACT_READ       = 4'd4;
    localparam logic [ACTION_W-1:0] ACT_WRITE      = 4'd5;
    localparam logic [ACTION_W-1:0] ACT_CLEAR      = 4'd6;
    localparam logic [ACTION_W-1:0] ACT_ROTATE     = 4'd7;
    localparam logic [ACTION_W-1:0] ACT_REMOVE     = 4'd8;
    localparam logic [ACTION_W-1:0] ACT_COUNT      = 4'd9;
    localparam logic [ACTION_W-1:0] ACT_CONTAINS   = 4'd10;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_POS_RANGE = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

    localparam logic CFG_MAX_LENGTH    = 1'b0;
    localparam logic CFG_LIMIT_ENABLED = 1'b1;

endpackage

// ===== rtl/bounded_deque_engine.sv =====
// ----------------------------------------------------------------------------
// Bounded deque engine
// Double-ended queue of words held in a ring memory, with end pushes and pops,
// indexed access, rotate, remove, count and search.
// ----------------------------------------------------------------------------
// One word is taken at a time and gives one result word. Pushes, pops, read,
// write, clear, unused actions and a rotate of an empty queue go straight to
// the output state. Rotate of a nonempty queue first reduces the step count
// modulo the length in a 16-step restoring divider.
// Count, contains and remove walk the ring memory through its single read
// port, one entry a cycle; contains stops at the first equal word, and remove
// moves the later words down while it walks. The memory contents need no
// clearing after reset. The input side is free again as soon as a result
// sits in the output register.
module bounded_deque_engine #(
    parameter int DEPTH      = 256,
    parameter int DATA_WIDTH = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic                         cfg_index,
    input  logic [bdq_pkg::CFG_W-1:0]    cfg_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [bdq_pkg::ACTION_W-1:0] action,
    input  logic [bdq_pkg::VALUE_W-1:0]  value,
    input  logic signed [bdq_pkg::POS_W-1:0] position,
    input  logic signed [bdq_pkg::POS_W-1:0] rotate_steps,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [bdq_pkg::VALUE_W-1:0]  item,
    output logic [bdq_pkg::STATUS_W-1:0] status,
    output logic [$clog2(DEPTH+1)-1:0]   match_count,
    output logic                         found,
    output logic                         dropped,
    output logic [$clog2(DEPTH+1)-1:0]   length
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int LIM_W = (CNT_W > bdq_pkg::CFG_W) ? CNT_W : bdq_pkg::CFG_W;
    localparam int PW    = ((CNT_W > bdq_pkg::POS_W) ? CNT_W : bdq_pkg::POS_W) + 2;
    localparam int DIV_STEPS = bdq_pkg::POS_W;
    localparam int DCNT_W = $clog2(DIV_STEPS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_DIV,
        S_ROT,
        S_OUT
    } state_t;

    function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] a,
                                                   input logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = (CNT_W+1)'(a) + (CNT_W+1)'(b);
        if (s >= (CNT_W+1)'(DEPTH))
        begin
            s = s - (CNT_W+1)'(DEPTH);
        end
        return PTR_W'(s);
    endfunction

    function automatic logic [PTR_W-1:0] wrap_sub(input logic [PTR_W-1:0] a,
                                                   input logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = (CNT_W+1)'(a) + (CNT_W+1)'(DEPTH) - (CNT_W+1)'(b);
        if (s >= (CNT_W+1)'(DEPTH))
        begin
            s = s - (CNT_W+1)'(DEPTH);
        end
        return PTR_W'(s);
    endfunction

    // Ring memory with registered read data.
    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic                  mem_we;
    logic [PTR_W-1:0]      mem_waddr;
    logic [DATA_WIDTH-1:0] mem_wdata;
    logic                  mem_re;
    logic [PTR_W-1:0]      mem_raddr;
    logic [DATA_WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    state_t                        state_reg, state_next;
    logic [bdq_pkg::ACTION_W-1:0]  action_reg, action_next;
    logic [DATA_WIDTH-1:0]         value_reg, value_next;
    logic [PTR_W-1:0]              front_reg, front_next;
    logic [CNT_W-1:0]              count_reg, count_next;
    logic [CNT_W-1:0]              idx_reg, idx_next;
    logic [PTR_W-1:0]              rp_reg, rp_next;
    logic [PTR_W-1:0]              cp_reg, cp_next;
    logic [PTR_W-1:0]              wp_reg, wp_next;
    logic [DIV_STEPS-1:0]          div_q_reg, div_q_next;
    logic [DCNT_W-1:0]             div_cnt_reg, div_cnt_next;
    logic                          neg_reg, neg_next;
    logic [CNT_W-1:0]              rem_reg, rem_next;
    logic [bdq_pkg::STATUS_W-1:0]  res_status_reg, res_status_next;
    logic [CNT_W-1:0]              res_match_reg, res_match_next;
    logic                          res_found_reg, res_found_next;
    logic                          res_dropped_reg, res_dropped_next;
    logic                          res_mem_reg, res_mem_next;
    logic                          out_valid_reg, out_valid_next;
    logic [bdq_pkg::VALUE_W-1:0]   item_reg, item_next;
    logic [bdq_pkg::STATUS_W-1:0]  status_reg, status_next;
    logic [CNT_W-1:0]              match_count_reg, match_count_next;
    logic                          found_reg, found_next;
    logic                          dropped_reg, dropped_next;
    logic [CNT_W-1:0]              length_reg, length_next;
    logic [bdq_pkg::CFG_W-1:0]     max_length_reg, max_length_next;
    logic                          limit_en_reg, limit_en_next;

    logic                  accept;
    logic [DATA_WIDTH-1:0] value_w;
    logic [LIM_W-1:0]      lim;
    logic                  lim_full;
    logic                  depth_full;
    logic signed [PW-1:0]  p_ext;
    logic signed [PW-1:0]  p_adj;
    logic signed [PW-1:0]  cnt_s;
    logic                  in_range;
    logic [CNT_W-1:0]      p_idx;
    logic                  hit;
    logic                  last;
    logic [CNT_W:0]        div_t;
    logic [DIV_STEPS-1:0]  steps_abs;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign value_w  = DATA_WIDTH'(value);

    assign lim = (LIM_W'(max_length_reg) > LIM_W'(DEPTH)) ? LIM_W'(DEPTH)
                                                          : LIM_W'(max_length_reg);
    assign lim_full   = LIM_W'(count_reg) >= lim;
    assign depth_full = count_reg == CNT_W'(DEPTH);

    // A negative position counts from the back.
    assign p_ext    = PW'(position);
    assign cnt_s    = $signed(PW'(count_reg));
    assign p_adj    = position[bdq_pkg::POS_W-1] ? p_ext + cnt_s : p_ext;
    assign in_range = !p_adj[PW-1] && (p_adj < cnt_s);
    assign p_idx    = p_adj[CNT_W-1:0];

    assign hit  = rdata_reg == value_reg;
    assign last = idx_reg == count_reg;

    assign steps_abs = rotate_steps[bdq_pkg::POS_W-1] ? DIV_STEPS'(-rotate_steps)
                                                      : DIV_STEPS'(rotate_steps);
    assign div_t = {rem_reg, div_q_reg[DIV_STEPS-1]};

    always_comb
    begin
        state_next       = state_reg;
        action_next      = action_reg;
        value_next       = value_reg;
        front_next       = front_reg;
        count_next       = count_reg;
        idx_next         = idx_reg;
        rp_next          = rp_reg;
        cp_next          = cp_reg;
        wp_next          = wp_reg;
        div_q_next       = div_q_reg;
        div_cnt_next     = div_cnt_reg;
        neg_next         = neg_reg;
        rem_next         = rem_reg;
        res_status_next  = res_status_reg;
        res_match_next   = res_match_reg;
        res_found_next   = res_found_reg;
        res_dropped_next = res_dropped_reg;
        res_mem_next     = res_mem_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        item_next        = item_reg;
        status_next      = status_reg;
        match_count_next = match_count_reg;
        found_next       = found_reg;
        dropped_next     = dropped_reg;
        length_next      = length_reg;
        max_length_next  = max_length_reg;
        limit_en_next    = limit_en_reg;
        mem_we           = 1'b0;
        mem_waddr        = front_reg;
        mem_wdata        = value_w;
        mem_re           = 1'b0;
        mem_raddr        = front_reg;

        if (cfg_we)
        begin
            unique case (cfg_index)
                bdq_pkg::CFG_MAX_LENGTH:    max_length_next = cfg_data;
                bdq_pkg::CFG_LIMIT_ENABLED: limit_en_next   = cfg_data[0];
                default:                    ;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    action_next      = action;
                    value_next       = value_w;
                    res_status_next  = bdq_pkg::ST_OK;
                    res_match_next   = '0;
                    res_found_next   = 1'b0;
                    res_dropped_next = 1'b0;
                    res_mem_next     = 1'b0;
                    state_next       = S_OUT;
                    unique case (action)
                        bdq_pkg::ACT_PUSH_BACK, bdq_pkg::ACT_PUSH_FRONT:
                        begin
                            if (limit_en_reg && lim == '0)
                            begin
                                // Zero limit: the push has no effect.
                            end
                            else if (!limit_en_reg && depth_full)
                            begin
                                res_status_next = bdq_pkg::ST_FULL;
                            end
                            else
                            begin
                                mem_we = 1'b1;
                                if (action == bdq_pkg::ACT_PUSH_FRONT)
                                begin
                                    mem_waddr  = wrap_sub(front_reg, CNT_W'(1));
                                    front_next = wrap_sub(front_reg, CNT_W'(1));
                                end
                                else
                                begin
                                    // Dropping the front leaves the back slot
                                    // at the same physical place.
                                    mem_waddr = wrap_add(front_reg, count_reg);
                                    if (limit_en_reg && lim_full)
                                    begin
                                        front_next = wrap_add(front_reg, CNT_W'(1));
                                    end
                                end
                                if (limit_en_reg && lim_full)
                                begin
                                    res_dropped_next = 1'b1;
                                end
                                else
                                begin
                                    count_next = count_reg + CNT_W'(1);
                                end
                            end
                        end
                        bdq_pkg::ACT_POP_BACK, bdq_pkg::ACT_POP_FRONT:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_next = bdq_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                mem_re       = 1'b1;
                                res_mem_next = 1'b1;
                                count_next   = count_reg - CNT_W'(1);
                                if (action == bdq_pkg::ACT_POP_BACK)
                                begin
                                    mem_raddr = wrap_add(front_reg, count_reg - CNT_W'(1));
                                end
                                else
                                begin
                                    front_next = wrap_add(front_reg, CNT_W'(1));
                                end
                            end
                        end
                        bdq_pkg::ACT_READ, bdq_pkg::ACT_WRITE:
                        begin
                            if (!in_range)
                            begin
                                res_status_next = bdq_pkg::ST_POS_RANGE;
                            end
                            else if (action == bdq_pkg::ACT_READ)
                            begin
                                mem_re       = 1'b1;
                                mem_raddr    = wrap_add(front_reg, p_idx);
                                res_mem_next = 1'b1;
                            end
                            else
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = wrap_add(front_reg, p_idx);
                            end
                        end
                        bdq_pkg::ACT_CLEAR:
                        begin
                            count_next = '0;
                            front_next = '0;
                        end
                        bdq_pkg::ACT_ROTATE:
                        begin
                            if (count_reg != '0)
                            begin
                                div_q_next   = steps_abs;
                                div_cnt_next = '0;
                                rem_next     = '0;
                                neg_next     = rotate_steps[bdq_pkg::POS_W-1];
                                state_next   = S_DIV;
                            end
                        end
                        bdq_pkg::ACT_REMOVE, bdq_pkg::ACT_COUNT,
                        bdq_pkg::ACT_CONTAINS:
                        begin
                            if (count_reg == '0)
                            begin
                                if (action == bdq_pkg::ACT_REMOVE)
                                begin
                                    res_status_next = bdq_pkg::ST_NOT_FOUND;
                                end
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = front_reg;
                                rp_next    = wrap_add(front_reg, CNT_W'(1));
                                cp_next    = front_reg;
                                idx_next   = CNT_W'(1);
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_SCAN, S_SHIFT:
            begin
                // rdata_reg holds the word at cp_reg; the read ahead runs one
                // entry in front of it.
                if (!last)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = rp_reg;
                    rp_next   = wrap_add(rp_reg, CNT_W'(1));
                    cp_next   = rp_reg;
                    idx_next  = idx_reg + CNT_W'(1);
                end
                wp_next = cp_reg;
                if (state_reg == S_SHIFT)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = wp_reg;
                    mem_wdata = rdata_reg;
                    if (last)
                    begin
                        count_next = count_reg - CNT_W'(1);
                        state_next = S_OUT;
                    end
                end
                else
                begin
                    priority if (action_reg == bdq_pkg::ACT_COUNT)
                    begin
                        if (hit)
                        begin
                            res_match_next = res_match_reg + CNT_W'(1);
                        end
                        if (last)
                        begin
                            state_next = S_OUT;
                        end
                    end
                    else if (action_reg == bdq_pkg::ACT_CONTAINS)
                    begin
                        if (hit)
                        begin
                            res_found_next = 1'b1;
                        end
                        if (hit || last)
                        begin
                            state_next = S_OUT;
                        end
                    end
                    else
                    begin
                        if (hit && last)
                        begin
                            count_next = count_reg - CNT_W'(1);
                            state_next = S_OUT;
                        end
                        else if (hit)
                        begin
                            state_next = S_SHIFT;
                        end
                        else if (last)
                        begin
                            res_status_next = bdq_pkg::ST_NOT_FOUND;
                            state_next      = S_OUT;
                        end
                    end
                end
            end
            S_DIV:
            begin
                if (div_t >= (CNT_W+1)'(count_reg))
                begin
                    rem_next = CNT_W'(div_t - (CNT_W+1)'(count_reg));
                end
                else
                begin
                    rem_next = CNT_W'(div_t);
                end
                div_q_next   = {div_q_reg[DIV_STEPS-2:0], 1'b0};
                div_cnt_next = div_cnt_reg + DCNT_W'(1);
                if (div_cnt_reg == DCNT_W'(DIV_STEPS - 1))
                begin
                    state_next = S_ROT;
                end
            end
            S_ROT:
            begin
                if (rem_reg != '0)
                begin
                    front_next = neg_reg ? wrap_add(front_reg, rem_reg)
                                         : wrap_sub(front_reg, rem_reg);
                end
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next   = 1'b1;
                    item_next        = res_mem_reg ? bdq_pkg::VALUE_W'(rdata_reg) : '0;
                    status_next      = res_status_reg;
                    match_count_next = res_match_reg;
                    found_next       = res_found_reg;
                    dropped_next     = res_dropped_reg;
                    length_next      = count_reg;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            action_reg      <= '0;
            value_reg       <= '0;
            front_reg       <= '0;
            count_reg       <= '0;
            idx_reg         <= '0;
            rp_reg          <= '0;
            cp_reg          <= '0;
            wp_reg          <= '0;
            div_q_reg       <= '0;
            div_cnt_reg     <= '0;
            neg_reg         <= 1'b0;
            rem_reg         <= '0;
            res_status_reg  <= '0;
            res_match_reg   <= '0;
            res_found_reg   <= 1'b0;
            res_dropped_reg <= 1'b0;
            res_mem_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
            item_reg        <= '0;
            status_reg      <= '0;
            match_count_reg <= '0;
            found_reg       <= 1'b0;
            dropped_reg     <= 1'b0;
            length_reg      <= '0;
            max_length_reg  <= bdq_pkg::CFG_W'(256);
            limit_en_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            action_reg      <= action_next;
            value_reg       <= value_next;
            front_reg       <= front_next;
            count_reg       <= count_next;
            idx_reg         <= idx_next;
            rp_reg          <= rp_next;
            cp_reg          <= cp_next;
            wp_reg          <= wp_next;
            div_q_reg       <= div_q_next;
            div_cnt_reg     <= div_cnt_next;
            neg_reg         <= neg_next;
            rem_reg         <= rem_next;
            res_status_reg  <= res_status_next;
            res_match_reg   <= res_match_next;
            res_found_reg   <= res_found_next;
            res_dropped_reg <= res_dropped_next;
            res_mem_reg     <= res_mem_next;
            out_valid_reg   <= out_valid_next;
            item_reg        <= item_next;
            status_reg      <= status_next;
            match_count_reg <= match_count_next;
            found_reg       <= found_next;
            dropped_reg     <= dropped_next;
            length_reg      <= length_next;
            max_length_reg  <= max_length_next;
            limit_en_reg    <= limit_en_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign item        = item_reg;
    assign status      = status_reg;
    assign match_count = match_count_reg;
    assign found       = found_reg;
    assign dropped     = dropped_reg;
    assign length      = length_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("word count exceeds the ring depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("result word presented outside the output state");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN || state_reg == S_SHIFT) |-> count_reg != '0)
        else $error("memory walk running on an empty queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN || state_reg == S_SHIFT) |-> idx_reg <= count_reg)
        else $error("walk index ran past the queue length");

endmodule
